// ===== rtl/urichk_pkg.sv =====
package urichk_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_QUERY   = 8'h3F;

    // Depth of each of the two internal queues.
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ESC_PLAIN = 2'd0,
        ESC_HIGH  = 2'd1,
        ESC_LOW   = 2'd2
    } t_esc;

    // One classified input byte, handed from the front to the back.
    typedef struct packed {
        logic [7:0] dec_byte;
        logic       have;
        logic       bad;
        logic       open_esc;
        logic       last;
    } t_token;

    // One finished result.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       done_res;
        logic       accepted;
    } t_result;

    // Bit 4 is set for a hex digit; bits 3:0 carry its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30 : 8'h39]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[8'h41 : 8'h46], [8'h61 : 8'h66]}) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// ===== rtl/uri_percent_decode_check.sv =====
// Channel   Direction  Handshake         Payload
// input     in         push / full       i_in_byte, i_in_last
// result    out        pop / empty       o_out_byte, o_out_valid, o_done_res, o_accepted
//
// One byte is taken per clock cycle while full is low; each transfer in yields exactly one result.
// A byte passes through the token queue and then the result queue before its result can be popped.
// Both two-entry queues keep full rate while the result side pops every cycle.
// Reset is synchronous and active low; it empties both queues and the URI state.
// A stall on pop fills the result queue, then the token queue, then raises full.

module uri_percent_decode_check (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_out_valid,
    output logic       o_done_res,
    output logic       o_accepted
);

    // The front decodes percent escapes and plus signs into tokens; the
    // back applies the path rules and gives the verdict on the last byte.
    urichk_pkg::t_token  tok;
    urichk_pkg::t_result res;
    logic                tok_empty;
    logic                tok_pop;

    urichk_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_full      (full),
        .i_tok_pop   (tok_pop),
        .o_tok_empty (tok_empty),
        .o_tok       (tok)
    );

    urichk_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_empty (tok_empty),
        .i_tok       (tok),
        .o_tok_pop   (tok_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (res)
    );

    // The result fields come straight from the head of the result queue.
    assign o_out_byte  = res.out_byte;
    assign o_out_valid = res.out_valid;
    assign o_done_res  = res.done_res;
    assign o_accepted  = res.accepted;

    // After reset both queues are empty, so nothing is shown and input is open.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // A verdict of accepted only appears on the result of the last byte.
    a_accept_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_accepted) |-> o_done_res)
        else $error("accepted without done");

    // A result that carries no decoded byte shows a zero byte.
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out_valid) |-> (o_out_byte == 8'd0))
        else $error("byte not zero without valid");

    // Input stalls only when the front queue holds tokens it cannot pass on.
    a_full_backed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !tok_empty)
        else $error("full with empty token queue");

endmodule

// ===== rtl/urichk_front.sv =====
module urichk_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [7:0]         i_in_byte,
    input  logic               i_in_last,
    output logic               o_full,
    input  logic               i_tok_pop,
    output logic               o_tok_empty,
    output urichk_pkg::t_token o_tok
);

    urichk_pkg::t_esc   r_phase, n_phase;
    logic [3:0]         r_high, n_high;
    logic               r_bad, n_bad;

    urichk_pkg::t_token r_q [urichk_pkg::QUEUE_DEPTH];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_cnt;

    urichk_pkg::t_token tok;
    logic [4:0]         hex;
    logic               take;

    assign o_full      = (r_cnt == 2'(urichk_pkg::QUEUE_DEPTH));
    assign o_tok_empty = (r_cnt == 2'd0);
    assign o_tok       = r_q[r_rd_ptr];
    assign take        = i_push && !o_full;
    assign hex         = urichk_pkg::hex_digit(i_in_byte);

    // Escape tracking and classification of the incoming byte.
    always_comb begin
        n_phase      = r_phase;
        n_high       = r_high;
        n_bad        = r_bad;
        tok.dec_byte = 8'd0;
        tok.have     = 1'b0;
        tok.bad      = r_bad;
        tok.last     = i_in_last;
        if (!r_bad) begin
            case (r_phase)
                urichk_pkg::ESC_HIGH: begin
                    if (hex[4]) begin
                        n_high  = hex[3:0];
                        n_phase = urichk_pkg::ESC_LOW;
                    end else begin
                        n_bad = 1'b1;
                    end
                end
                urichk_pkg::ESC_LOW: begin
                    if (hex[4]) begin
                        tok.dec_byte = {r_high, hex[3:0]};
                        tok.have     = 1'b1;
                        n_phase      = urichk_pkg::ESC_PLAIN;
                    end else begin
                        n_bad = 1'b1;
                    end
                end
                default: begin
                    n_phase = urichk_pkg::ESC_PLAIN;
                    if (i_in_byte == urichk_pkg::CH_PERCENT) begin
                        n_phase = urichk_pkg::ESC_HIGH;
                    end else if (i_in_byte == urichk_pkg::CH_PLUS) begin
                        tok.dec_byte = urichk_pkg::CH_SPACE;
                        tok.have     = 1'b1;
                    end else begin
                        tok.dec_byte = i_in_byte;
                        tok.have     = 1'b1;
                    end
                end
            endcase
        end
        tok.bad      = n_bad;
        tok.open_esc = (n_phase != urichk_pkg::ESC_PLAIN);
        if (i_in_last) begin
            n_phase = urichk_pkg::ESC_PLAIN;
            n_high  = 4'd0;
            n_bad   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= urichk_pkg::ESC_PLAIN;
            r_high   <= 4'd0;
            r_bad    <= 1'b0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (take) begin
                r_phase  <= n_phase;
                r_high   <= n_high;
                r_bad    <= n_bad;
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_tok_pop && !o_tok_empty) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= r_cnt + 2'(take) - 2'(i_tok_pop && !o_tok_empty);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_q[r_wr_ptr] <= tok;
        end
    end

endmodule

// ===== rtl/urichk_back.sv =====
module urichk_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tok_empty,
    input  urichk_pkg::t_token  i_tok,
    output logic                o_tok_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output urichk_pkg::t_result o_res
);

    logic                r_any, n_any;
    logic                r_prev_dot, n_prev_dot;
    logic                r_query, n_query;
    logic                r_rej, n_rej;

    urichk_pkg::t_result r_q [urichk_pkg::QUEUE_DEPTH];
    logic                r_wr_ptr;
    logic                r_rd_ptr;
    logic [1:0]          r_cnt;

    urichk_pkg::t_result res;
    logic                full;
    logic                deq;

    assign full      = (r_cnt == 2'(urichk_pkg::QUEUE_DEPTH));
    assign o_empty   = (r_cnt == 2'd0);
    assign o_res     = r_q[r_rd_ptr];
    assign o_tok_pop = !i_tok_empty && !full;
    assign deq       = i_pop && !o_empty;

    // Path checks on the decoded stream and the verdict on the last byte.
    always_comb begin
        n_any         = r_any;
        n_prev_dot    = r_prev_dot;
        n_query       = r_query;
        n_rej         = r_rej;
        res.out_byte  = 8'd0;
        res.out_valid = 1'b0;
        res.done_res  = i_tok.last;
        res.accepted  = 1'b0;
        if (!r_rej) begin
            if (i_tok.bad) begin
                n_rej = 1'b1;
            end else if (i_tok.have) begin
                if (!r_any && i_tok.dec_byte != urichk_pkg::CH_SLASH) begin
                    n_rej = 1'b1;
                end else if (i_tok.dec_byte == urichk_pkg::CH_DOT && r_prev_dot
                             && !r_query) begin
                    n_rej = 1'b1;
                end else begin
                    res.out_byte  = i_tok.dec_byte;
                    res.out_valid = 1'b1;
                    n_any         = 1'b1;
                    n_prev_dot    = (i_tok.dec_byte == urichk_pkg::CH_DOT);
                    if (i_tok.dec_byte == urichk_pkg::CH_QUERY) begin
                        n_query = 1'b1;
                    end
                end
            end
        end
        if (i_tok.last) begin
            res.accepted = !(n_rej || i_tok.open_esc || !n_any);
            n_any        = 1'b0;
            n_prev_dot   = 1'b0;
            n_query      = 1'b0;
            n_rej        = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any      <= 1'b0;
            r_prev_dot <= 1'b0;
            r_query    <= 1'b0;
            r_rej      <= 1'b0;
            r_wr_ptr   <= 1'b0;
            r_rd_ptr   <= 1'b0;
            r_cnt      <= 2'd0;
        end else begin
            if (o_tok_pop) begin
                r_any      <= n_any;
                r_prev_dot <= n_prev_dot;
                r_query    <= n_query;
                r_rej      <= n_rej;
                r_wr_ptr   <= ~r_wr_ptr;
            end
            if (deq) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= r_cnt + 2'(o_tok_pop) - 2'(deq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tok_pop) begin
            r_q[r_wr_ptr] <= res;
        end
    end

endmodule
